[hdl/vpnt_pkg.sv]
`default_nettype none

package vpnt_pkg;

   // field widths
   localparam int POS_W    = 24;
   localparam int NRM_W    = 16;
   localparam int COEF_W   = 18;
   localparam int SCALE_W  = 20;
   localparam int MODE_W   = 11;
   localparam int ROW_W    = 3 * COEF_W;
   localparam int SCALES_W = 3 * SCALE_W;
   localparam int OFFXY_W  = 2 * POS_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = SCALES_W;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROT_ROW_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROT_ROW_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROT_ROW_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_XYZ = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_XY = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Z  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_BITS = 3'd6;

   // reset values
   localparam logic [ROW_W-1:0]    ROT_ROW_0_RESET = 54'd65536;
   localparam logic [ROW_W-1:0]    ROT_ROW_1_RESET = 54'd65536 << COEF_W;
   localparam logic [ROW_W-1:0]    ROT_ROW_2_RESET = 54'd65536 << (2 * COEF_W);
   localparam logic [SCALES_W-1:0] SCALE_RESET =
      60'd4096 | (60'd4096 << SCALE_W) | (60'd4096 << (2 * SCALE_W));
   localparam logic [MODE_W-1:0]   MODE_RESET = 11'd136;

   localparam int MODE_ROT_BIT    = 9;
   localparam int MODE_NSCALE_BIT = 10;

   // axis source codes
   localparam logic [2:0] AXIS_PX = 3'd0;
   localparam logic [2:0] AXIS_PY = 3'd1;
   localparam logic [2:0] AXIS_PZ = 3'd2;
   localparam logic [2:0] AXIS_NX = 3'd3;
   localparam logic [2:0] AXIS_NY = 3'd4;
   localparam logic [2:0] AXIS_NZ = 3'd5;

   // pipeline depths
   localparam int NDIV_STEPS  = 40;   // quotient bits of the normal scaling
   localparam int NSH_STEPS   = 6;    // normalize shifter: 32,16,8,4,2,1
   localparam int SQRT_STEPS  = 31;   // root bits
   localparam int QDIV_STEPS  = 15;   // unit quotient bits
   localparam int UNIT_FRAC   = 14;
   localparam int POS_STAGES  = 6;
   localparam int NRM_STAGES  = (NDIV_STEPS + 1) + 4 + (NSH_STEPS + 1) + 1
                                + (SQRT_STEPS + 1) + (QDIV_STEPS + 1) + 1;
   localparam int POS_DELAY   = NRM_STAGES - POS_STAGES;
   localparam int LATENCY     = NRM_STAGES + 1;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [NRM_W-1:0] nrm_x;
      logic signed [NRM_W-1:0] nrm_y;
      logic signed [NRM_W-1:0] nrm_z;
   } req_word_type;

   typedef struct packed {
      logic signed [POS_W-1:0] world_x;
      logic signed [POS_W-1:0] world_y;
      logic signed [POS_W-1:0] world_z;
      logic signed [NRM_W-1:0] unit_x;
      logic signed [NRM_W-1:0] unit_y;
      logic signed [NRM_W-1:0] unit_z;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0][2:0][COEF_W-1:0] coef;    // [row][col]
      logic [2:0][SCALE_W-1:0]     scale;
      logic [2:0][POS_W-1:0]       offset;
      logic [2:0][2:0]             axis;
      logic                        rotate;
      logic                        nscale;
   } cfg_type;

endpackage

`default_nettype wire

[hdl/vertex_position_normal_transform.sv]
`default_nettype none

// Vertex model-to-world transform, one vertex word per clock.
// Request: a word is taken at a rising edge with start high and busy low.
//   busy is only high during reset and in the cycle after it, so vertices may stream
//   with start held high every cycle.
// Response: rsp_strobe is high for one cycle with rsp_word; the receiver
//   cannot stall and needs none, there is no back pressure anywhere.
// Path: input register, then the normal path (40-step scaling divider,
//   remap/rotate, 6-step normalize shifter, 31-step square root and a
//   15-step unit divider). The position path takes 6 stages and is
//   delayed to line up. Throughput: one vertex per cycle.
// Config: csr_we writes csr_wdata into register csr_index at a rising
//   edge; only change it while the pipe is empty. Unknown indexes drop.
// Reset: synchronous; clears the pipe valid bits (in-flight vertices are
//   dropped) and loads identity matrix, unit scale, zero offset, xyz map.
module vertex_position_normal_transform (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  vpnt_pkg::req_word_type                  req_word,
   output logic                                    rsp_strobe,
   output vpnt_pkg::rsp_word_type                  rsp_word,
   input  logic                                    csr_we,
   input  logic [vpnt_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [vpnt_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import vpnt_pkg::*;

   // config registers
   logic [2:0][ROW_W-1:0] rot_ff;
   logic [SCALES_W-1:0]   scale_ff;
   logic [OFFXY_W-1:0]    offxy_ff;
   logic [POS_W-1:0]      offz_ff;
   logic [MODE_W-1:0]     mode_ff;
   cfg_type               cfg;

   // input register
   logic                  busy_ff;
   logic                  in_v_ff;
   logic                  in_v_in;
   req_word_type          in_word_ff;

   // path outputs
   logic [2:0][POS_W-1:0] pos_world;
   logic [2:0][POS_W-1:0] pos_dly_ff [POS_DELAY];
   logic                  nrm_valid;
   logic [2:0][NRM_W-1:0] nrm_unit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ROT_ROW_0_RESET;
         rot_ff[1] <= ROT_ROW_1_RESET;
         rot_ff[2] <= ROT_ROW_2_RESET;
         scale_ff  <= SCALE_RESET;
         offxy_ff  <= '0;
         offz_ff   <= '0;
         mode_ff   <= MODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROT_ROW_0: rot_ff[0] <= csr_wdata[ROW_W-1:0];
            CSR_ROT_ROW_1: rot_ff[1] <= csr_wdata[ROW_W-1:0];
            CSR_ROT_ROW_2: rot_ff[2] <= csr_wdata[ROW_W-1:0];
            CSR_SCALE_XYZ: scale_ff  <= csr_wdata[SCALES_W-1:0];
            CSR_OFFSET_XY: offxy_ff  <= csr_wdata[OFFXY_W-1:0];
            CSR_OFFSET_Z:  offz_ff   <= csr_wdata[POS_W-1:0];
            CSR_MODE_BITS: mode_ff   <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // unpack the register fields for both paths
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            cfg.coef[r][c] = rot_ff[r][COEF_W*c +: COEF_W];
         end
         cfg.scale[r] = scale_ff[SCALE_W*r +: SCALE_W];
         cfg.axis[r]  = mode_ff[3*r +: 3];
      end
      cfg.offset[0] = offxy_ff[POS_W-1:0];
      cfg.offset[1] = offxy_ff[OFFXY_W-1:POS_W];
      cfg.offset[2] = offz_ff;
      cfg.rotate    = mode_ff[MODE_ROT_BIT];
      cfg.nscale    = mode_ff[MODE_NSCALE_BIT];
   end

   assign in_v_in = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         in_v_ff <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         in_v_ff <= in_v_in;
      end
      in_word_ff <= req_word;
   end

   assign busy = busy_ff;

   vpnt_pos u_pos (
      .clock   (clock),
      .in_word (in_word_ff),
      .cfg     (cfg),
      .world   (pos_world)
   );

   vpnt_nrm u_nrm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_v_ff),
      .in_word   (in_word_ff),
      .cfg       (cfg),
      .out_valid (nrm_valid),
      .out_unit  (nrm_unit)
   );

   // hold the position until the normal catches up
   always_ff @(posedge clock) begin
      pos_dly_ff[0] <= pos_world;
      for (int k = 1; k < POS_DELAY; k++) begin
         pos_dly_ff[k] <= pos_dly_ff[k-1];
      end
   end

   assign rsp_strobe       = nrm_valid;
   assign rsp_word.world_x = pos_dly_ff[POS_DELAY-1][0];
   assign rsp_word.world_y = pos_dly_ff[POS_DELAY-1][1];
   assign rsp_word.world_z = pos_dly_ff[POS_DELAY-1][2];
   assign rsp_word.unit_x  = nrm_unit[0];
   assign rsp_word.unit_y  = nrm_unit[1];
   assign rsp_word.unit_z  = nrm_unit[2];

endmodule

`default_nettype wire

[hdl/vpnt_pos.sv]
`default_nettype none

module vpnt_pos (
   input  logic                             clock,
   input  vpnt_pkg::req_word_type           in_word,
   input  vpnt_pkg::cfg_type                cfg,
   output logic [2:0][vpnt_pkg::POS_W-1:0]  world
);
   import vpnt_pkg::*;

   localparam int ROT_FRAC   = 28;
   localparam int PLAIN_FRAC = 12;
   localparam logic signed [63:0] WORLD_MAX = 64'sd8388607;
   localparam logic signed [63:0] WORLD_MIN = -64'sd8388608;

   logic signed [43:0] sp_ff [3];
   logic signed [43:0] sp_in [3];
   logic signed [43:0] rm_ff [3];
   logic signed [43:0] rm_in [3];
   logic signed [61:0] pr_ff [3][3];
   logic signed [61:0] pr_in [3][3];
   logic signed [43:0] rb_ff [3];
   logic signed [63:0] cv_ff [3];
   logic signed [63:0] cv_in [3];
   logic signed [63:0] tv_ff [3];
   logic signed [63:0] tv_in [3];
   logic [2:0][POS_W-1:0] wo_ff;
   logic [2:0][POS_W-1:0] wo_in;
   logic signed [POS_W-1:0] pin [3];

   function automatic logic signed [43:0] pick_axis(input logic signed [43:0] v [3],
                                                     input logic [2:0] code);
      unique case (code)
         AXIS_PX: pick_axis = v[0];
         AXIS_PY: pick_axis = v[1];
         AXIS_PZ: pick_axis = v[2];
         AXIS_NX: pick_axis = -v[0];
         AXIS_NY: pick_axis = -v[1];
         AXIS_NZ: pick_axis = -v[2];
         default: pick_axis = '0;
      endcase
   endfunction

   assign pin[0] = in_word.pos_x;
   assign pin[1] = in_word.pos_y;
   assign pin[2] = in_word.pos_z;

   always_comb begin
      logic signed [SCALE_W-1:0] s;
      logic signed [63:0]        oe;
      logic signed [63:0]        sh;
      for (int i = 0; i < 3; i++) begin
         s        = $signed(cfg.scale[i]);
         sp_in[i] = pin[i] * s;
         rm_in[i] = pick_axis(sp_ff, cfg.axis[i]);
         for (int c = 0; c < 3; c++) begin
            pr_in[i][c] = $signed(cfg.coef[i][c]) * rm_ff[c];
         end
         if (cfg.rotate) begin
            cv_in[i] = pr_ff[i][0] + pr_ff[i][1] + pr_ff[i][2];
         end else begin
            cv_in[i] = rb_ff[i];
         end
         oe = 64'($signed(cfg.offset[i]));
         if (cfg.rotate) begin
            tv_in[i] = cv_ff[i] + (oe <<< ROT_FRAC) + (64'sd1 <<< (ROT_FRAC - 1));
            sh       = tv_ff[i] >>> ROT_FRAC;
         end else begin
            tv_in[i] = cv_ff[i] + (oe <<< PLAIN_FRAC) + (64'sd1 <<< (PLAIN_FRAC - 1));
            sh       = tv_ff[i] >>> PLAIN_FRAC;
         end
         if (sh > WORLD_MAX) begin
            wo_in[i] = WORLD_MAX[POS_W-1:0];
         end else if (sh < WORLD_MIN) begin
            wo_in[i] = WORLD_MIN[POS_W-1:0];
         end else begin
            wo_in[i] = sh[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      sp_ff <= sp_in;
      rm_ff <= rm_in;
      pr_ff <= pr_in;
      rb_ff <= rm_ff;
      cv_ff <= cv_in;
      tv_ff <= tv_in;
      wo_ff <= wo_in;
   end

   assign world = wo_ff;

endmodule

`default_nettype wire

[hdl/vpnt_nrm.sv]
`default_nettype none

module vpnt_nrm (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  vpnt_pkg::req_word_type           in_word,
   input  vpnt_pkg::cfg_type                cfg,
   output logic                             out_valid,
   output logic [2:0][vpnt_pkg::NRM_W-1:0]  out_unit
);
   import vpnt_pkg::*;

   localparam int MAG_W = 60;

   typedef struct packed {
      logic [2:0][SCALE_W-1:0]    rem;
      logic [2:0][NDIV_STEPS-1:0] num;
      logic [2:0][NDIV_STEPS-1:0] quo;
      logic [2:0][NRM_W-1:0]      nrm;
      logic [2:0][SCALE_W-1:0]    dvs;
      logic [2:0]                 neg;
   } div_stage_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  zero;
   } shift_stage_type;

   typedef struct packed {
      logic [61:0]      rem;
      logic [30:0]      root;
      logic [2:0][29:0] ax;
      logic [2:0]       neg;
      logic             zero;
   } sqrt_stage_type;

   typedef struct packed {
      logic [2:0][44:0] rem;
      logic [2:0][14:0] quo;
      logic [30:0]      len;
      logic [2:0]       neg;
      logic             zero;
   } quot_stage_type;

   logic [NRM_STAGES-1:0] vld_ff;
   div_stage_type   dv_ff [NDIV_STEPS+1];
   div_stage_type   dv_in [NDIV_STEPS+1];
   logic signed [40:0] sc_ff [3];
   logic signed [40:0] sc_in [3];
   logic signed [40:0] rm_ff [3];
   logic signed [40:0] rm_in [3];
   logic signed [58:0] pr_ff [3][3];
   logic signed [58:0] pr_in [3][3];
   logic signed [40:0] rd_ff [3];
   logic signed [60:0] cv_ff [3];
   logic signed [60:0] cv_in [3];
   shift_stage_type sh_ff [NSH_STEPS+1];
   shift_stage_type sh_in [NSH_STEPS+1];
   logic [2:0][29:0] hax_ff, hax_in;
   logic [2:0][59:0] hsq_ff, hsq_in;
   logic [2:0]       hng_ff;
   logic             hzr_ff;
   sqrt_stage_type  sq_ff [SQRT_STEPS+1];
   sqrt_stage_type  sq_in [SQRT_STEPS+1];
   quot_stage_type  qd_ff [QDIV_STEPS+1];
   quot_stage_type  qd_in [QDIV_STEPS+1];
   logic [2:0][NRM_W-1:0] un_ff, un_in;
   logic signed [NRM_W-1:0] nin [3];

   function automatic logic signed [40:0] pick_axis(input logic signed [40:0] v [3],
                                                     input logic [2:0] code);
      unique case (code)
         AXIS_PX: pick_axis = v[0];
         AXIS_PY: pick_axis = v[1];
         AXIS_PZ: pick_axis = v[2];
         AXIS_NX: pick_axis = -v[0];
         AXIS_NY: pick_axis = -v[1];
         AXIS_NZ: pick_axis = -v[2];
         default: pick_axis = '0;
      endcase
   endfunction

   assign nin[0] = in_word.nrm_x;
   assign nin[1] = in_word.nrm_y;
   assign nin[2] = in_word.nrm_z;

   // scaling divider: magnitude long division, one quotient bit per stage
   always_comb begin
      div_stage_type             cur;
      div_stage_type             nxt;
      logic [SCALE_W:0]          t;
      logic                      ge;
      logic signed [SCALE_W-1:0] s;
      logic [NRM_W-1:0]          mn;
      for (int i = 0; i < 3; i++) begin
         s  = $signed(cfg.scale[i]);
         mn = nin[i][NRM_W-1] ? NRM_W'(-nin[i]) : nin[i];
         dv_in[0].rem[i] = '0;
         dv_in[0].num[i] = {mn, {(NDIV_STEPS - NRM_W){1'b0}}};
         dv_in[0].quo[i] = '0;
         dv_in[0].nrm[i] = nin[i];
         if (s == 0) begin
            dv_in[0].dvs[i] = SCALE_W'(1);  // zero scale divides by one LSB
         end else begin
            dv_in[0].dvs[i] = s[SCALE_W-1] ? SCALE_W'(-s) : s;
         end
         dv_in[0].neg[i] = nin[i][NRM_W-1] ^ s[SCALE_W-1];
      end
      for (int j = 1; j <= NDIV_STEPS; j++) begin
         cur = dv_ff[j-1];
         nxt = cur;
         for (int i = 0; i < 3; i++) begin
            t  = {cur.rem[i], cur.num[i][NDIV_STEPS-1]};
            ge = t >= {1'b0, cur.dvs[i]};
            nxt.rem[i] = ge ? SCALE_W'(t - {1'b0, cur.dvs[i]}) : t[SCALE_W-1:0];
            nxt.num[i] = {cur.num[i][NDIV_STEPS-2:0], 1'b0};
            nxt.quo[i] = {cur.quo[i][NDIV_STEPS-2:0], ge};
         end
         dv_in[j] = nxt;
      end
   end

   // sign, remap, rotate
   always_comb begin
      logic signed [40:0] qs;
      for (int i = 0; i < 3; i++) begin
         qs = {1'b0, dv_ff[NDIV_STEPS].quo[i]};
         if (cfg.nscale) begin
            sc_in[i] = dv_ff[NDIV_STEPS].neg[i] ? -qs : qs;
         end else begin
            sc_in[i] = 41'($signed(dv_ff[NDIV_STEPS].nrm[i]));
         end
         rm_in[i] = pick_axis(sc_ff, cfg.axis[i]);
         for (int c = 0; c < 3; c++) begin
            pr_in[i][c] = $signed(cfg.coef[i][c]) * rm_ff[c];
         end
         if (cfg.rotate) begin
            cv_in[i] = pr_ff[i][0] + pr_ff[i][1] + pr_ff[i][2];
         end else begin
            cv_in[i] = rd_ff[i];
         end
      end
   end

   // magnitude, then common left shift until the largest has its top bit at the top
   always_comb begin
      logic [MAG_W-1:0] om;
      int               amt;
      for (int i = 0; i < 3; i++) begin
         sh_in[0].mag[i] = cv_ff[i][60] ? MAG_W'(-cv_ff[i]) : MAG_W'(cv_ff[i]);
         sh_in[0].neg[i] = cv_ff[i][60];
      end
      sh_in[0].zero = (cv_ff[0] == 0) && (cv_ff[1] == 0) && (cv_ff[2] == 0);
      for (int k = 1; k <= NSH_STEPS; k++) begin
         amt      = 1 << (NSH_STEPS - k);
         om       = sh_ff[k-1].mag[0] | sh_ff[k-1].mag[1] | sh_ff[k-1].mag[2];
         sh_in[k] = sh_ff[k-1];
         if ((om >> (MAG_W - amt)) == '0) begin
            for (int i = 0; i < 3; i++) begin
               sh_in[k].mag[i] = sh_ff[k-1].mag[i] << amt;
            end
         end
      end
      // top 30 bits and their squares land in the same stage
      for (int i = 0; i < 3; i++) begin
         hax_in[i] = sh_ff[NSH_STEPS].mag[i][MAG_W-1:MAG_W-30];
         hsq_in[i] = hax_in[i] * hax_in[i];
      end
   end

   // integer square root, one root bit per stage
   always_comb begin
      sqrt_stage_type cur;
      sqrt_stage_type nxt;
      logic [63:0]    dlt;
      logic           ge;
      int             b;
      sq_in[0].rem  = 62'(hsq_ff[0]) + 62'(hsq_ff[1]) + 62'(hsq_ff[2]);
      sq_in[0].root = '0;
      sq_in[0].ax   = hax_ff;
      sq_in[0].neg  = hng_ff;
      sq_in[0].zero = hzr_ff;
      for (int j = 1; j <= SQRT_STEPS; j++) begin
         b   = SQRT_STEPS - j;
         cur = sq_ff[j-1];
         nxt = cur;
         dlt = (64'(cur.root) << (b + 1)) | (64'(1) << (2 * b));
         ge  = 64'(cur.rem) >= dlt;
         if (ge) begin
            nxt.rem  = 62'(64'(cur.rem) - dlt);
            nxt.root = cur.root | (31'(1) << b);
         end
         sq_in[j] = nxt;
      end
   end

   // unit components: round(a * 2^14 / len), one quotient bit per stage
   always_comb begin
      quot_stage_type cur;
      quot_stage_type nxt;
      logic [45:0]    dd;
      int             b;
      qd_in[0].len  = sq_ff[SQRT_STEPS].root;
      qd_in[0].neg  = sq_ff[SQRT_STEPS].neg;
      qd_in[0].zero = sq_ff[SQRT_STEPS].zero;
      qd_in[0].quo  = '0;
      for (int i = 0; i < 3; i++) begin
         qd_in[0].rem[i] = 45'({sq_ff[SQRT_STEPS].ax[i], {UNIT_FRAC{1'b0}}})
                           + 45'(sq_ff[SQRT_STEPS].root[30:1]);
      end
      for (int j = 1; j <= QDIV_STEPS; j++) begin
         b   = QDIV_STEPS - j;
         cur = qd_ff[j-1];
         nxt = cur;
         dd  = 46'(cur.len) << b;
         for (int i = 0; i < 3; i++) begin
            if (46'(cur.rem[i]) >= dd) begin
               nxt.rem[i] = 45'(46'(cur.rem[i]) - dd);
               nxt.quo[i] = cur.quo[i] | (15'(1) << b);
            end
         end
         qd_in[j] = nxt;
      end
      for (int i = 0; i < 3; i++) begin
         if (qd_ff[QDIV_STEPS].zero) begin
            un_in[i] = '0;
         end else if (qd_ff[QDIV_STEPS].neg[i]) begin
            un_in[i] = NRM_W'(-{1'b0, qd_ff[QDIV_STEPS].quo[i]});
         end else begin
            un_in[i] = {1'b0, qd_ff[QDIV_STEPS].quo[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NRM_STAGES-2:0], in_valid};
      end
      dv_ff  <= dv_in;
      sc_ff  <= sc_in;
      rm_ff  <= rm_in;
      pr_ff  <= pr_in;
      rd_ff  <= rm_ff;
      cv_ff  <= cv_in;
      sh_ff  <= sh_in;
      hax_ff <= hax_in;
      hsq_ff <= hsq_in;
      hng_ff <= sh_ff[NSH_STEPS].neg;
      hzr_ff <= sh_ff[NSH_STEPS].zero;
      sq_ff  <= sq_in;
      qd_ff  <= qd_in;
      un_ff  <= un_in;
   end

   assign out_valid = vld_ff[NRM_STAGES-1];
   assign out_unit  = un_ff;

endmodule

`default_nettype wire

[hdl/vpnt_checker.sv]
`default_nettype none

module vpnt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input vpnt_pkg::req_word_type req_word,
   input logic                   rsp_strobe,
   input vpnt_pkg::rsp_word_type rsp_word
);
   import vpnt_pkg::*;

   // reset empties the pipe and blocks the next word
   a_reset_flush: assert property (@(posedge clock)
      reset |=> (busy && !rsp_strobe))
      else $error("pipe not flushed by reset");

   // every accepted word comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted word not delivered on time");

   // no word appears that was not accepted
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("word delivered without a request");

   // a zero normal gives a zero unit vector
   a_zero_normal: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.nrm_x == 0 && req_word.nrm_y == 0
       && req_word.nrm_z == 0)
      |-> ##LATENCY (rsp_word.unit_x == 0 && rsp_word.unit_y == 0
                     && rsp_word.unit_z == 0))
      else $error("zero normal not mapped to zero");

endmodule

bind vertex_position_normal_transform vpnt_checker u_vpnt_checker (.*);

`default_nettype wire
